/* src/s2c_pkg.sv */
// Shared types, constants and calendar helpers for the seconds to calendar converter.
package s2c_pkg;

	localparam int unsigned SecsW    = 32;
	localparam int unsigned YearW    = 12;
	localparam int unsigned UnitW    = 18;
	localparam int unsigned DaysW    = 16;
	localparam int unsigned TodW     = 17;
	localparam int unsigned OutDataW = 40;

	localparam logic [UnitW-1:0] SecsPerDay  = 18'd86400;
	localparam logic [UnitW-1:0] SecsPerHour = 18'd3600;
	localparam logic [UnitW-1:0] SecsPerMin  = 18'd60;
	localparam logic [UnitW-1:0] YearsPerEra = 18'd400;
	localparam logic [UnitW-1:0] DaysCommon  = 18'd365;
	localparam logic [UnitW-1:0] DaysLeap    = 18'd366;
	localparam logic [YearW-1:0] BaseYearRst = 12'd2019;
	localparam logic [8:0]       EraLast     = 9'd399;
	localparam logic [3:0]       MonthDec    = 4'd11;

	// sequencer states, one-hot
	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_DAYDIV = 8'b0000_0010,
		ST_YMOD   = 8'b0000_0100,
		ST_YEAR   = 8'b0000_1000,
		ST_MONTH  = 8'b0001_0000,
		ST_HOUR   = 8'b0010_0000,
		ST_MIN    = 8'b0100_0000,
		ST_FINISH = 8'b1000_0000
	} state_t;

	// operands and result of the shared compare-subtract unit
	typedef struct packed {
		logic [UnitW-1:0] a;
		logic [UnitW-1:0] b;
	} sub_req_t;

	typedef struct packed {
		logic             ge;
		logic [UnitW-1:0] diff;
	} sub_rsp_t;

	// leap test from the year modulo 400
	function automatic logic is_leap(input logic [8:0] r400);
		logic res;
		res = (r400[1:0] == 2'd0) && (r400 != 9'd100) && (r400 != 9'd200)
			&& (r400 != 9'd300);
		return res;
	endfunction

	// month length, month index from 0
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m) inside
			4'd1:                      len = leap ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

/* src/s2c_sub.sv */
// Shared compare-subtract unit: a - b and the flag a >= b.
module s2c_sub (
	input  s2c_pkg::sub_req_t req,
	output s2c_pkg::sub_rsp_t rsp
);

	logic [s2c_pkg::UnitW:0] wide;

	assign wide     = {1'b0, req.a} - {1'b0, req.b};
	assign rsp.ge   = ~wide[s2c_pkg::UnitW];
	assign rsp.diff = wide[s2c_pkg::UnitW-1:0];

endmodule

/* src/seconds_to_calendar.sv */
// Top level: seconds count to Gregorian date and time, one shared subtractor under a sequencer.
// Steps: day division, year modulo 400, year walk, month walk, hour and minute division.
// One conversion runs at a time, and the year walk dominates its run time.
// Input is taken only while the sequencer idles; a finished result waits in the output
// register, so the next conversion runs while the previous result is still unclaimed.
// Reset (arst_n low, asynchronous): sequencer idle, output empty, base_year back to 2019.
module seconds_to_calendar (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [11:0] cfg_wdata,     // base_year
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,       // [31:0] seconds_count
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata        // [11:0] year, [15:12] month, [20:16] day,
	                                   // [25:21] hour, [31:26] minute, [37:32] second,
	                                   // [39:38] zero
);

	s2c_pkg::state_t state_q;
	logic [4:0]  cnt_q;
	logic [11:0] base_q;
	logic        out_valid_q;

	// datapath
	logic [31:0] secs_q;     // dividend, shifts out while the day quotient shifts in
	logic [17:0] wrk_q;      // partial remainder
	logic [15:0] days_q;
	logic [16:0] tod_q;
	logic [11:0] year_q;
	logic [8:0]  r400_q;     // year modulo 400, drives the leap test
	logic [3:0]  month_q;
	logic [4:0]  hour_q;
	logic [5:0]  minute_q;
	logic [39:0] out_q;

	s2c_pkg::sub_req_t sub_req;
	s2c_pkg::sub_rsp_t sub_rsp;
	logic [17:0] rem_nxt;
	logic        leap;
	logic        last_step;
	logic        out_load;

	s2c_sub u_sub (
		.req (sub_req),
		.rsp (sub_rsp)
	);

	assign leap      = s2c_pkg::is_leap(r400_q);
	assign last_step = (cnt_q == 5'd0);
	assign rem_nxt   = sub_rsp.ge ? sub_rsp.diff : sub_req.a;
	assign out_load  = (state_q == s2c_pkg::ST_FINISH) && (!out_valid_q || m_tready);

	// Operand selection for the one shared unit. Hour, minute and the year-mod-400 step
	// use a shifted divisor, since each quotient is known to be short.
	always_comb begin
		sub_req.a = wrk_q;
		sub_req.b = s2c_pkg::SecsPerDay;
		unique case (state_q) inside
			s2c_pkg::ST_DAYDIV: begin
				sub_req.a = {wrk_q[16:0], secs_q[31]};
				sub_req.b = s2c_pkg::SecsPerDay;
			end
			s2c_pkg::ST_YMOD: begin
				sub_req.b = s2c_pkg::YearsPerEra << cnt_q[1:0];
			end
			s2c_pkg::ST_YEAR: begin
				sub_req.a = {2'b00, days_q};
				sub_req.b = leap ? s2c_pkg::DaysLeap : s2c_pkg::DaysCommon;
			end
			s2c_pkg::ST_MONTH: begin
				sub_req.a = {2'b00, days_q};
				sub_req.b = {13'd0, s2c_pkg::month_len(month_q, leap)};
			end
			s2c_pkg::ST_HOUR: begin
				sub_req.b = s2c_pkg::SecsPerHour << cnt_q[2:0];
			end
			s2c_pkg::ST_MIN: begin
				sub_req.b = s2c_pkg::SecsPerMin << cnt_q[2:0];
			end
			s2c_pkg::ST_IDLE, s2c_pkg::ST_FINISH: begin
				sub_req.a = wrk_q;
			end
			default: begin
				sub_req.a = wrk_q;
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= s2c_pkg::BaseYearRst;
		end else if (cfg_wen) begin
			base_q <= cfg_wdata;
		end
	end

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= s2c_pkg::ST_IDLE;
			cnt_q       <= 5'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				s2c_pkg::ST_IDLE: begin
					if (s_tvalid) begin
						cnt_q   <= 5'd31;
						state_q <= s2c_pkg::ST_DAYDIV;
					end
				end
				s2c_pkg::ST_DAYDIV: begin
					if (last_step) begin
						cnt_q   <= 5'd3;
						state_q <= s2c_pkg::ST_YMOD;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				s2c_pkg::ST_YMOD: begin
					if (last_step) begin
						state_q <= s2c_pkg::ST_YEAR;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				s2c_pkg::ST_YEAR: begin
					if (!sub_rsp.ge) begin
						state_q <= s2c_pkg::ST_MONTH;
					end
				end
				s2c_pkg::ST_MONTH: begin
					if (!sub_rsp.ge || month_q == s2c_pkg::MonthDec) begin
						cnt_q   <= 5'd4;
						state_q <= s2c_pkg::ST_HOUR;
					end
				end
				s2c_pkg::ST_HOUR: begin
					if (last_step) begin
						cnt_q   <= 5'd5;
						state_q <= s2c_pkg::ST_MIN;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				s2c_pkg::ST_MIN: begin
					if (last_step) begin
						state_q <= s2c_pkg::ST_FINISH;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				s2c_pkg::ST_FINISH: begin
					if (out_load) begin
						state_q <= s2c_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= s2c_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			s2c_pkg::ST_IDLE: begin
				secs_q <= s_tdata;
				wrk_q  <= '0;
			end
			s2c_pkg::ST_DAYDIV: begin
				secs_q <= {secs_q[30:0], sub_rsp.ge};
				if (last_step) begin
					days_q <= {secs_q[14:0], sub_rsp.ge};
					tod_q  <= rem_nxt[16:0];
					wrk_q  <= {6'd0, base_q};
				end else begin
					wrk_q  <= rem_nxt;
				end
			end
			s2c_pkg::ST_YMOD: begin
				wrk_q <= rem_nxt;
				if (last_step) begin
					r400_q <= rem_nxt[8:0];
					year_q <= base_q;
				end
			end
			s2c_pkg::ST_YEAR: begin
				if (sub_rsp.ge) begin
					days_q <= sub_rsp.diff[15:0];
					year_q <= year_q + 12'd1;
					r400_q <= (r400_q == s2c_pkg::EraLast) ? 9'd0 : r400_q + 9'd1;
				end else begin
					month_q <= 4'd0;
				end
			end
			s2c_pkg::ST_MONTH: begin
				if (sub_rsp.ge && month_q != s2c_pkg::MonthDec) begin
					days_q  <= sub_rsp.diff[15:0];
					month_q <= month_q + 4'd1;
				end else begin
					wrk_q <= {1'b0, tod_q};
				end
			end
			s2c_pkg::ST_HOUR: begin
				hour_q <= {hour_q[3:0], sub_rsp.ge};
				wrk_q  <= rem_nxt;
			end
			s2c_pkg::ST_MIN: begin
				minute_q <= {minute_q[4:0], sub_rsp.ge};
				wrk_q    <= rem_nxt;
			end
			s2c_pkg::ST_FINISH: begin
				if (out_load) begin
					out_q <= {2'b00, wrk_q[5:0], minute_q, hour_q, days_q[4:0] + 5'd1,
						month_q + 4'd1, year_q};
				end
			end
			default: begin
				wrk_q <= wrk_q;
			end
		endcase
	end

	assign s_tready = (state_q == s2c_pkg::ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	// a taken transaction always starts a multi-cycle conversion
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted twice in a row");

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	// month walk never passes December, and the remaining days fit in one year
	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == s2c_pkg::ST_MONTH) |-> (month_q <= s2c_pkg::MonthDec) && (days_q < 16'd366))
		else $error("month walk out of range");

	a_out_month: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:12] != 4'd0) && (m_tdata[15:12] <= 4'd12))
		else $error("result month out of range");

	// a pending result is not overwritten before it is taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("pending result lost");

endmodule
